// ----- rtl/i2c_memory_transaction_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// I2C memory transaction sequencer: assertion macros
// Shared property templates for the concurrent checks of the sequencer.
// ----------------------------------------------------------------------------
`ifndef I2C_MEMORY_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MEMORY_TRANSACTION_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMTS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IMTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/imts_pkg.sv -----
// ----------------------------------------------------------------------------
// imts_pkg
// Op codes, engine action codes, status codes and the result bundle type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imts_pkg;

  // Input op codes.
  localparam logic [3:0] OP_WRITE_CMD  = 4'd0;
  localparam logic [3:0] OP_READ_CMD   = 4'd1;
  localparam logic [3:0] OP_START_DONE = 4'd2;
  localparam logic [3:0] OP_ADDR_ACK   = 4'd3;
  localparam logic [3:0] OP_NACK       = 4'd4;
  localparam logic [3:0] OP_TX_EMPTY   = 4'd5;
  localparam logic [3:0] OP_RX_BYTE    = 4'd6;
  localparam logic [3:0] OP_WRITE_BYTE = 4'd7;
  localparam logic [3:0] OP_TICK       = 4'd8;

  // Engine action codes.
  localparam logic [3:0] ACT_START    = 4'd0;
  localparam logic [3:0] ACT_SEND     = 4'd1;
  localparam logic [3:0] ACT_STOP     = 4'd2;
  localparam logic [3:0] ACT_ACK      = 4'd3;
  localparam logic [3:0] ACT_NACK     = 4'd4;
  localparam logic [3:0] ACT_NEED     = 4'd5;
  localparam logic [3:0] ACT_READ     = 4'd6;
  localparam logic [3:0] ACT_RESET    = 4'd7;
  localparam logic [3:0] ACT_REENABLE = 4'd8;
  localparam logic [3:0] ACT_CLRNACK  = 4'd9;
  localparam logic [3:0] ACT_DONE     = 4'd10;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_NACKED  = 2'd3;

  localparam int MAX_ACTIONS = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  // All actions caused by one request. At most one of them carries a byte
  // and at most one carries a status, so one field of each suffices.
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [MAX_ACTIONS-1:0][3:0]  act;
    logic [7:0]                   data;
    logic [1:0]                   status;
  } bundle_t;

endpackage

// ----- rtl/imts_front.sv -----
// ----------------------------------------------------------------------------
// imts_front
// Transaction state machine: classifies each request against the current
// phase, updates the state and builds the bundle of engine actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imts_front #(
  parameter int MAX_ADDR_BYTES = 2,
  parameter int TIMEOUT_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [3:0]        op_i,
  input  logic [6:0]        dev_addr_i,
  input  logic [15:0]       mem_addr_i,
  input  logic [1:0]        addr_bytes_i,
  input  logic [15:0]       length_i,
  input  logic [15:0]       timeout_ms_i,
  input  logic [7:0]        data_byte_i,
  input  logic              bus_busy_i,
  input  logic              lines_idle_i,
  input  logic              master_mode_i,
  input  logic              ctrl_extra_i,
  output logic              push_o,
  output imts_pkg::bundle_t bundle_o
);

  localparam int AbW = $clog2(MAX_ADDR_BYTES + 1);
  localparam logic [31:0] TmoMax = 32'((64'd1 << TIMEOUT_BITS) - 64'd1);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_START  = 4'd1;
  localparam logic [3:0] PH_ADDR_W = 4'd2;
  localparam logic [3:0] PH_MADDR  = 4'd3;
  localparam logic [3:0] PH_NEED   = 4'd4;
  localparam logic [3:0] PH_TXDATA = 4'd5;
  localparam logic [3:0] PH_RSTART = 4'd6;
  localparam logic [3:0] PH_ADDR_R = 4'd7;
  localparam logic [3:0] PH_RECV   = 4'd8;

  logic [3:0]              phase_q, phase_d;
  logic                    is_read_q, is_read_d;
  logic [6:0]              target_q, target_d;
  logic [15:0]             maddr_q, maddr_d;
  logic [AbW-1:0]          abl_q, abl_d;
  logic [15:0]             total_q, total_d;
  logic [15:0]             done_q, done_d;
  logic [TIMEOUT_BITS-1:0] reload_q, reload_d;
  logic [TIMEOUT_BITS-1:0] tleft_q, tleft_d;

  logic [AbW-1:0]          abl_sat;
  logic [AbW-1:0]          sel;
  logic [7:0]              maddr_byte;
  logic [31:0]             tmo_ext;
  logic [TIMEOUT_BITS-1:0] tmo_sat;
  logic [15:0]             done_inc;

  assign abl_sat  = (addr_bytes_i > 2'(MAX_ADDR_BYTES)) ? AbW'(MAX_ADDR_BYTES)
                                                          : AbW'(addr_bytes_i);
  assign sel        = abl_q - AbW'(1);
  assign maddr_byte = maddr_q[8*sel +: 8];
  assign tmo_ext    = 32'(timeout_ms_i);
  assign tmo_sat    = (tmo_ext > TmoMax) ? TIMEOUT_BITS'(TmoMax)
                                         : TIMEOUT_BITS'(tmo_ext);
  assign done_inc   = done_q + 16'd1;

  always_comb begin
    imts_pkg::bundle_t b;
    logic [2:0]        n;
    b         = '0;
    n         = '0;
    phase_d   = phase_q;
    is_read_d = is_read_q;
    target_d  = target_q;
    maddr_d   = maddr_q;
    abl_d     = abl_q;
    total_d   = total_q;
    done_d    = done_q;
    reload_d  = reload_q;
    tleft_d   = tleft_q;

    unique case (op_i) inside
      imts_pkg::OP_WRITE_CMD, imts_pkg::OP_READ_CMD: begin
        if (phase_q == PH_IDLE) begin
          if (bus_busy_i) begin
            // Recovery: a reset leaves the engine neither master nor with
            // extra control bits, so nothing else is needed after it.
            if (lines_idle_i) begin
              b.act[n[1:0]] = imts_pkg::ACT_RESET; n = n + 3'd1;
            end else begin
              if (master_mode_i) begin
                b.act[n[1:0]] = imts_pkg::ACT_STOP; n = n + 3'd1;
              end
              if (ctrl_extra_i) begin
                b.act[n[1:0]] = imts_pkg::ACT_REENABLE; n = n + 3'd1;
              end
            end
            b.act[n[1:0]] = imts_pkg::ACT_DONE; n = n + 3'd1;
            b.status = imts_pkg::ST_BUSY;
          end else begin
            is_read_d = (op_i == imts_pkg::OP_READ_CMD);
            target_d  = dev_addr_i;
            maddr_d   = mem_addr_i;
            abl_d     = abl_sat;
            total_d   = length_i;
            done_d    = '0;
            reload_d  = tmo_sat;
            tleft_d   = tmo_sat;
            b.act[n[1:0]] = imts_pkg::ACT_START; n = n + 3'd1;
            phase_d   = PH_START;
          end
        end
      end
      imts_pkg::OP_START_DONE: begin
        if (phase_q == PH_START || phase_q == PH_RSTART) begin
          b.act[n[1:0]] = imts_pkg::ACT_SEND; n = n + 3'd1;
          b.data   = {target_q, (phase_q == PH_RSTART)};
          tleft_d  = reload_q;
          phase_d  = (phase_q == PH_RSTART) ? PH_ADDR_R : PH_ADDR_W;
        end
      end
      imts_pkg::OP_ADDR_ACK, imts_pkg::OP_TX_EMPTY: begin
        if ((op_i == imts_pkg::OP_ADDR_ACK && phase_q == PH_ADDR_W) ||
            (op_i == imts_pkg::OP_TX_EMPTY && phase_q == PH_MADDR)) begin
          if (abl_q != '0) begin
            b.act[n[1:0]] = imts_pkg::ACT_SEND; n = n + 3'd1;
            b.data  = maddr_byte;
            abl_d   = abl_q - AbW'(1);
            phase_d = PH_MADDR;
          end else if (is_read_q) begin
            b.act[n[1:0]] = imts_pkg::ACT_START; n = n + 3'd1;
            tleft_d = reload_q;
            phase_d = PH_RSTART;
          end else if (total_q != '0) begin
            b.act[n[1:0]] = imts_pkg::ACT_NEED; n = n + 3'd1;
            phase_d = PH_NEED;
          end else begin
            b.act[n[1:0]] = imts_pkg::ACT_STOP; n = n + 3'd1;
            b.act[n[1:0]] = imts_pkg::ACT_DONE; n = n + 3'd1;
            b.status = imts_pkg::ST_OK;
            phase_d  = PH_IDLE;
          end
        end else if (op_i == imts_pkg::OP_ADDR_ACK && phase_q == PH_ADDR_R) begin
          if (total_q == '0) begin
            // An empty read completes without a stop.
            b.act[n[1:0]] = imts_pkg::ACT_DONE; n = n + 3'd1;
            b.status = imts_pkg::ST_OK;
            phase_d  = PH_IDLE;
          end else begin
            if (total_q == 16'd1) begin
              b.act[n[1:0]] = imts_pkg::ACT_NACK; n = n + 3'd1;
              b.act[n[1:0]] = imts_pkg::ACT_STOP; n = n + 3'd1;
            end else begin
              b.act[n[1:0]] = imts_pkg::ACT_ACK; n = n + 3'd1;
            end
            phase_d = PH_RECV;
          end
        end else if (op_i == imts_pkg::OP_TX_EMPTY && phase_q == PH_TXDATA) begin
          done_d = done_inc;
          if (done_inc < total_q) begin
            b.act[n[1:0]] = imts_pkg::ACT_NEED; n = n + 3'd1;
            phase_d = PH_NEED;
          end else begin
            b.act[n[1:0]] = imts_pkg::ACT_STOP; n = n + 3'd1;
            b.act[n[1:0]] = imts_pkg::ACT_DONE; n = n + 3'd1;
            b.status = imts_pkg::ST_OK;
            phase_d  = PH_IDLE;
          end
        end
      end
      imts_pkg::OP_NACK: begin
        if (phase_q == PH_ADDR_W || phase_q == PH_ADDR_R ||
            phase_q == PH_MADDR || phase_q == PH_TXDATA) begin
          b.act[n[1:0]] = imts_pkg::ACT_STOP; n = n + 3'd1;
          // A nack on a data or memory address byte also leaves a flag to clear.
          if (phase_q == PH_MADDR || phase_q == PH_TXDATA) begin
            b.act[n[1:0]] = imts_pkg::ACT_CLRNACK; n = n + 3'd1;
          end
          b.act[n[1:0]] = imts_pkg::ACT_DONE; n = n + 3'd1;
          b.status = imts_pkg::ST_NACKED;
          phase_d  = PH_IDLE;
        end
      end
      imts_pkg::OP_RX_BYTE: begin
        if (phase_q == PH_RECV) begin
          b.act[n[1:0]] = imts_pkg::ACT_READ; n = n + 3'd1;
          b.data = data_byte_i;
          done_d = done_inc;
          if (done_inc >= total_q) begin
            b.act[n[1:0]] = imts_pkg::ACT_DONE; n = n + 3'd1;
            b.status = imts_pkg::ST_OK;
            phase_d  = PH_IDLE;
          end else if (total_q - done_inc == 16'd1) begin
            b.act[n[1:0]] = imts_pkg::ACT_NACK; n = n + 3'd1;
            b.act[n[1:0]] = imts_pkg::ACT_STOP; n = n + 3'd1;
          end else begin
            b.act[n[1:0]] = imts_pkg::ACT_ACK; n = n + 3'd1;
          end
        end
      end
      imts_pkg::OP_WRITE_BYTE: begin
        if (phase_q == PH_NEED) begin
          b.act[n[1:0]] = imts_pkg::ACT_SEND; n = n + 3'd1;
          b.data  = data_byte_i;
          phase_d = PH_TXDATA;
        end
      end
      imts_pkg::OP_TICK: begin
        if (phase_q == PH_START || phase_q == PH_ADDR_W ||
            phase_q == PH_RSTART || phase_q == PH_ADDR_R) begin
          if (tleft_q <= TIMEOUT_BITS'(1)) begin
            tleft_d = '0;
            b.act[n[1:0]] = imts_pkg::ACT_DONE; n = n + 3'd1;
            b.status = imts_pkg::ST_TIMEOUT;
            phase_d  = PH_IDLE;
          end else begin
            tleft_d = tleft_q - TIMEOUT_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase

    b.cnt    = n;
    bundle_o = b;
  end

  assign push_o = fire_i && (bundle_o.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      is_read_q <= 1'b0;
      target_q  <= '0;
      maddr_q   <= '0;
      abl_q     <= '0;
      total_q   <= '0;
      done_q    <= '0;
      reload_q  <= '0;
      tleft_q   <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      target_q  <= target_d;
      maddr_q   <= maddr_d;
      abl_q     <= abl_d;
      total_q   <= total_d;
      done_q    <= done_d;
      reload_q  <= reload_d;
      tleft_q   <= tleft_d;
    end
  end

endmodule

// ----- rtl/imts_queue.sv -----
// ----------------------------------------------------------------------------
// imts_queue
// Short first-in first-out queue of action bundles between the state machine
// and the result serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imts_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  imts_pkg::bundle_t push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output imts_pkg::bundle_t head_o
);

  imts_pkg::bundle_t              mem_q [imts_pkg::QDEPTH];
  logic [imts_pkg::QPTR_W-1:0]    wptr_q, rptr_q;
  logic [imts_pkg::QPTR_W:0]      count_q;

  assign full_o  = (count_q == (imts_pkg::QPTR_W + 1)'(imts_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + imts_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + imts_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (imts_pkg::QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (imts_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ----- rtl/imts_back.sv -----
// ----------------------------------------------------------------------------
// imts_back
// Result serializer: steps through the actions of the bundle at the head of
// the queue, one result per cycle while out_ready_i is high, and flags the final one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  imts_pkg::bundle_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        action_o,
  output logic [7:0]        byte_out_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign out_valid_o = head_valid_i;
  assign action_o    = head_i.act[idx_q];
  assign last_o      = ({1'b0, idx_q} == head_i.cnt - 3'd1);
  assign byte_out_o  = (action_o == imts_pkg::ACT_SEND || action_o == imts_pkg::ACT_READ)
                       ? head_i.data : 8'd0;
  assign status_o    = (action_o == imts_pkg::ACT_DONE) ? head_i.status : 2'd0;

  assign fire  = out_valid_o && out_ready_i;
  assign pop_o = fire && last_o;
  assign idx_d = pop_o ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= idx_d;
    end
  end

endmodule

// ----- rtl/i2c_memory_transaction_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_memory_transaction_sequencer
// Each accepted request's bundle is written into the bundle queue, and the
// serializer reads results from its head. Throughput: one request per cycle while
// the four-entry bundle queue has room; the output side delivers one result per cycle
// while out_ready_i is high. Reset clears phase, pointers and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_memory_transaction_sequencer_macros.svh"

module i2c_memory_transaction_sequencer #(
  parameter int MAX_ADDR_BYTES = 2,
  parameter int TIMEOUT_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  op_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [15:0] mem_addr_i,
  input  logic [1:0]  addr_bytes_i,
  input  logic [15:0] length_i,
  input  logic [15:0] timeout_ms_i,
  input  logic [7:0]  data_byte_i,
  input  logic        bus_busy_i,
  input  logic        lines_idle_i,
  input  logic        master_mode_i,
  input  logic        ctrl_extra_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [7:0]  byte_out_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic              fire;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  imts_pkg::bundle_t bundle;
  imts_pkg::bundle_t head;

  assign in_ready_o = !full;
  assign fire       = in_valid_i && in_ready_o;

  imts_front #(
    .MAX_ADDR_BYTES(MAX_ADDR_BYTES),
    .TIMEOUT_BITS  (TIMEOUT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .op_i         (op_i),
    .dev_addr_i   (dev_addr_i),
    .mem_addr_i   (mem_addr_i),
    .addr_bytes_i (addr_bytes_i),
    .length_i     (length_i),
    .timeout_ms_i (timeout_ms_i),
    .data_byte_i  (data_byte_i),
    .bus_busy_i   (bus_busy_i),
    .lines_idle_i (lines_idle_i),
    .master_mode_i(master_mode_i),
    .ctrl_extra_i (ctrl_extra_i),
    .push_o       (push),
    .bundle_o     (bundle)
  );

  imts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(bundle),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  imts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .action_o    (action_o),
    .byte_out_o  (byte_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // A request whose results are only partly delivered keeps the output valid.
  `IMTS_ASSERT_NEXT(a_rest_pending, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o, out_valid_o, "results of a request were dropped")
  // With nothing queued the input side must be open.
  `IMTS_ASSERT_NOW(a_empty_ready, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with an empty queue")
  // Completion always closes the results of its request.
  `IMTS_ASSERT_NOW(a_done_last, clk_i, rst_ni, out_valid_o && action_o == imts_pkg::ACT_DONE, last_o, "done action not flagged as final")

endmodule

// ----- dv/i2c_memory_transaction_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// i2c_memory_transaction_sequencer_tb
// Self-checking bench for the I2C memory sequencer. A short directed table
// walks bus-busy recovery, write and read transactions, timeouts and nacks.
// A phase-aware random stream of commands and engine events follows. Every engine
// action is checked against a cycle-free model of the sequencer or a directed row's expected action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_memory_transaction_sequencer_tb;

  localparam logic [3:0] ACT_NONE     = 4'd11;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam int ADDR_BYTES_MAX = 2;
  localparam int RAND_ITEMS     = 160;
  localparam int CALM_ITEMS     = 40;
  localparam int PRESSURE_AT    = 60;
  localparam int HOLD_CYCLES    = 80;
  localparam int DIR_ROWS       = 31;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ADDR_W, S_MADDR, S_NEED, S_TXDATA, S_RSTART, S_ADDR_R, S_RECV
  } seq_phase_e;

  typedef struct packed {
    logic [3:0]  op;
    logic [6:0]  dev;
    logic [15:0] mem;
    logic [1:0]  ab;
    logic [15:0] len;
    logic [15:0] tmo;
    logic [7:0]  dat;
    logic        busy;
    logic        lidle;
    logic        mast;
    logic        extra;
  } req_t;

  typedef struct packed {
    logic [3:0] act;
    logic [7:0] data;
    logic [1:0] stat;
    logic       last;
  } action_t;

  typedef struct {
    req_t       item;
    logic [3:0] e_act;
    logic [7:0] e_data;
    logic [1:0] e_stat;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  op_i;
  logic [6:0]  dev_addr_i;
  logic [15:0] mem_addr_i;
  logic [1:0]  addr_bytes_i;
  logic [15:0] length_i;
  logic [15:0] timeout_ms_i;
  logic [7:0]  data_byte_i;
  logic        bus_busy_i;
  logic        lines_idle_i;
  logic        master_mode_i;
  logic        ctrl_extra_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  action_o;
  logic [7:0]  byte_out_o;
  logic [1:0]  status_o;
  logic        last_o;

  i2c_memory_transaction_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .dev_addr_i    (dev_addr_i),
    .mem_addr_i    (mem_addr_i),
    .addr_bytes_i  (addr_bytes_i),
    .length_i      (length_i),
    .timeout_ms_i  (timeout_ms_i),
    .data_byte_i   (data_byte_i),
    .bus_busy_i    (bus_busy_i),
    .lines_idle_i  (lines_idle_i),
    .master_mode_i (master_mode_i),
    .ctrl_extra_i  (ctrl_extra_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .byte_out_o    (byte_out_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sequencer model state.
  seq_phase_e  ph;
  logic        rd_xfer;
  logic [6:0]  tgt;
  logic [15:0] maddr;
  logic [1:0]  ab_left;
  logic [15:0] total;
  logic [15:0] done_cnt;
  logic [15:0] reload;
  logic [15:0] tleft;

  action_t pend[$];
  action_t expected_q[$];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      hold_arm = 1'b0;
  bit      hold_req = 1'b0;
  dir_row_t dir_tab[DIR_ROWS];

  task automatic flag(input string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic put(input logic [3:0] a, input logic [7:0] d, input logic [1:0] s);
    action_t x;
    x.act  = a;
    x.data = d;
    x.stat = s;
    x.last = 1'b0;
    pend.push_back(x);
  endtask

  task automatic complete(input logic [1:0] s);
    put(imts_pkg::ACT_DONE, 8'h00, s);
    ph = S_IDLE;
  endtask

  task automatic send_mem_byte();
    put(imts_pkg::ACT_SEND, (ab_left == 2'd2) ? maddr[15:8] : maddr[7:0], imts_pkg::ST_OK);
    ab_left = ab_left - 2'd1;
    ph = S_MADDR;
  endtask

  // Once the memory address is out: repeated start for reads, data or stop
  // for writes.
  task automatic turn_around();
    if (rd_xfer) begin
      put(imts_pkg::ACT_START, 8'h00, imts_pkg::ST_OK);
      tleft = reload;
      ph = S_RSTART;
    end else if (total != 16'd0) begin
      put(imts_pkg::ACT_NEED, 8'h00, imts_pkg::ST_OK);
      ph = S_NEED;
    end else begin
      put(imts_pkg::ACT_STOP, 8'h00, imts_pkg::ST_OK);
      complete(imts_pkg::ST_OK);
    end
  endtask

  task automatic read_ctrl();
    if (total - done_cnt == 16'd1) begin
      put(imts_pkg::ACT_NACK, 8'h00, imts_pkg::ST_OK);
      put(imts_pkg::ACT_STOP, 8'h00, imts_pkg::ST_OK);
    end else begin
      put(imts_pkg::ACT_ACK, 8'h00, imts_pkg::ST_OK);
    end
    ph = S_RECV;
  endtask

  task automatic reset_model();
    ph = S_IDLE;
    rd_xfer = 1'b0;
    tgt = '0;
    maddr = '0;
    ab_left = '0;
    total = '0;
    done_cnt = '0;
    reload = '0;
    tleft = '0;
  endtask

  // Applies one request to the model and leaves its actions in pend.
  task automatic apply_request(input req_t r, output bit changed);
    changed = 1'b0;
    pend.delete();
    case (r.op)
      imts_pkg::OP_WRITE_CMD, imts_pkg::OP_READ_CMD: begin
        if (ph == S_IDLE) begin
          if (r.busy) begin
            if (r.lidle) begin
              put(imts_pkg::ACT_RESET, 8'h00, imts_pkg::ST_OK);
            end else begin
              if (r.mast) put(imts_pkg::ACT_STOP, 8'h00, imts_pkg::ST_OK);
              if (r.extra) put(imts_pkg::ACT_REENABLE, 8'h00, imts_pkg::ST_OK);
            end
            complete(imts_pkg::ST_BUSY);
          end else begin
            rd_xfer = (r.op == imts_pkg::OP_READ_CMD);
            tgt = r.dev;
            maddr = r.mem;
            ab_left = (r.ab > ADDR_BYTES_MAX) ? 2'(ADDR_BYTES_MAX) : r.ab;
            total = r.len;
            done_cnt = '0;
            reload = r.tmo;
            tleft = reload;
            put(imts_pkg::ACT_START, 8'h00, imts_pkg::ST_OK);
            ph = S_START;
          end
        end
      end
      imts_pkg::OP_START_DONE: begin
        if (ph == S_START) begin
          put(imts_pkg::ACT_SEND, {tgt, 1'b0}, imts_pkg::ST_OK);
          tleft = reload;
          ph = S_ADDR_W;
        end else if (ph == S_RSTART) begin
          put(imts_pkg::ACT_SEND, {tgt, 1'b1}, imts_pkg::ST_OK);
          tleft = reload;
          ph = S_ADDR_R;
        end
      end
      imts_pkg::OP_ADDR_ACK: begin
        if (ph == S_ADDR_W) begin
          if (ab_left != 2'd0) send_mem_byte();
          else turn_around();
        end else if (ph == S_ADDR_R) begin
          if (total == 16'd0) complete(imts_pkg::ST_OK);
          else read_ctrl();
        end
      end
      imts_pkg::OP_NACK: begin
        if (ph == S_ADDR_W || ph == S_ADDR_R) begin
          put(imts_pkg::ACT_STOP, 8'h00, imts_pkg::ST_OK);
          complete(imts_pkg::ST_NACKED);
        end else if (ph == S_MADDR || ph == S_TXDATA) begin
          put(imts_pkg::ACT_STOP, 8'h00, imts_pkg::ST_OK);
          put(imts_pkg::ACT_CLRNACK, 8'h00, imts_pkg::ST_OK);
          complete(imts_pkg::ST_NACKED);
        end
      end
      imts_pkg::OP_TX_EMPTY: begin
        if (ph == S_MADDR) begin
          if (ab_left != 2'd0) send_mem_byte();
          else turn_around();
        end else if (ph == S_TXDATA) begin
          done_cnt = done_cnt + 16'd1;
          if (done_cnt < total) begin
            put(imts_pkg::ACT_NEED, 8'h00, imts_pkg::ST_OK);
            ph = S_NEED;
          end else begin
            put(imts_pkg::ACT_STOP, 8'h00, imts_pkg::ST_OK);
            complete(imts_pkg::ST_OK);
          end
        end
      end
      imts_pkg::OP_RX_BYTE: begin
        if (ph == S_RECV) begin
          put(imts_pkg::ACT_READ, r.dat, imts_pkg::ST_OK);
          done_cnt = done_cnt + 16'd1;
          if (done_cnt >= total) complete(imts_pkg::ST_OK);
          else read_ctrl();
        end
      end
      imts_pkg::OP_WRITE_BYTE: begin
        if (ph == S_NEED) begin
          put(imts_pkg::ACT_SEND, r.dat, imts_pkg::ST_OK);
          ph = S_TXDATA;
        end
      end
      imts_pkg::OP_TICK: begin
        if (ph == S_START || ph == S_ADDR_W || ph == S_RSTART || ph == S_ADDR_R) begin
          if (tleft <= 16'd1) begin
            tleft = '0;
            complete(imts_pkg::ST_TIMEOUT);
          end else begin
            tleft = tleft - 16'd1;
            changed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (pend.size() != 0) begin
      pend[pend.size()-1].last = 1'b1;
      changed = 1'b1;
    end
  endtask

  // Mostly the event the current phase waits for, with some noise mixed in.
  function automatic req_t next_item();
    req_t r;
    int   pick;
    r.op    = 4'($urandom_range(0, 15));
    r.dev   = 7'($urandom);
    r.mem   = 16'($urandom);
    r.ab    = 2'($urandom);
    r.len   = 16'($urandom);
    r.tmo   = 16'($urandom);
    r.dat   = 8'($urandom);
    r.busy  = 1'($urandom);
    r.lidle = 1'($urandom);
    r.mast  = 1'($urandom);
    r.extra = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Out-of-phase events; a command here only when it would be ignored.
      if (ph == S_IDLE) r.op = 4'($urandom_range(2, 15));
      return r;
    end
    case (ph)
      S_IDLE: begin
        r.op = $urandom_range(0, 1) ? imts_pkg::OP_READ_CMD : imts_pkg::OP_WRITE_CMD;
        r.busy = ($urandom_range(0, 9) == 0);
        if (r.op == imts_pkg::OP_READ_CMD) r.len = 16'($urandom_range(0, 5));
        else if ($urandom_range(0, 5) != 0) r.len = 16'($urandom_range(0, 4));
        if ($urandom_range(0, 3) != 0) r.tmo = 16'($urandom_range(0, 4));
      end
      S_START, S_RSTART: r.op = (pick < 85) ? imts_pkg::OP_START_DONE : imts_pkg::OP_TICK;
      S_ADDR_W, S_ADDR_R: r.op = (pick < 75) ? imts_pkg::OP_ADDR_ACK :
                                 (pick < 88) ? imts_pkg::OP_NACK : imts_pkg::OP_TICK;
      S_MADDR, S_TXDATA: r.op = (pick < 90) ? imts_pkg::OP_TX_EMPTY : imts_pkg::OP_NACK;
      S_NEED: r.op = imts_pkg::OP_WRITE_BYTE;
      default: r.op = imts_pkg::OP_RX_BYTE;
    endcase
    return r;
  endfunction

  // Offers one request, entered and left at a falling edge.
  task automatic offer(input req_t r, input logic [3:0] e_act, input logic [7:0] e_data,
                       input logic [1:0] e_stat, output bit changed);
    action_t x;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= r.op;
    dev_addr_i    <= r.dev;
    mem_addr_i    <= r.mem;
    addr_bytes_i  <= r.ab;
    length_i      <= r.len;
    timeout_ms_i  <= r.tmo;
    data_byte_i   <= r.dat;
    bus_busy_i    <= r.busy;
    lines_idle_i  <= r.lidle;
    master_mode_i <= r.mast;
    ctrl_extra_i  <= r.extra;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(r, changed);
    if (e_act != ACT_NONE) begin
      x.act  = e_act;
      x.data = e_data;
      x.stat = e_stat;
      x.last = 1'b1;
      expected_q.push_back(x);
    end else begin
      foreach (pend[k]) expected_q.push_back(pend[k]);
    end
    if (hold_arm) begin
      hold_arm = 1'b0;
      hold_req = 1'b1;
    end
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    bit changed;
    int n_eff;
    int iter;
    dir_tab = '{
      '{'{imts_pkg::OP_TICK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{OP_UNUSED_HI, 7'h7f, 16'hffff, 2'd3, 16'hffff, 16'hffff, 8'hff,
        1'b1, 1'b1, 1'b1, 1'b1}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      // Busy bus, nothing to recover.
      '{'{imts_pkg::OP_WRITE_CMD, 7'h11, 16'h0000, 2'd0, 16'd1, 16'd1, 8'h00,
        1'b1, 1'b0, 1'b0, 1'b0}, imts_pkg::ACT_DONE, 8'h00, imts_pkg::ST_BUSY},
      '{'{imts_pkg::OP_READ_CMD, 7'h11, 16'h0000, 2'd0, 16'd1, 16'd1, 8'h00,
        1'b1, 1'b1, 1'b1, 1'b1}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_WRITE_CMD, 7'h11, 16'h0000, 2'd0, 16'd1, 16'd1, 8'h00,
        1'b1, 1'b0, 1'b1, 1'b1}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      // Write with address and timeout at top value; three address bytes clamp to two.
      '{'{imts_pkg::OP_WRITE_CMD, 7'h7f, 16'hffff, 2'd3, 16'd1, 16'hffff, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, imts_pkg::ACT_START, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_READ_CMD, 7'h55, 16'h1234, 2'd1, 16'd2, 16'd2, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_START_DONE, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, imts_pkg::ACT_SEND, 8'hfe, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_ADDR_ACK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_TX_EMPTY, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_TX_EMPTY, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_WRITE_BYTE, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'hff,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_TX_EMPTY, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      // Zero-length write with everything at zero.
      '{'{imts_pkg::OP_WRITE_CMD, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, imts_pkg::ACT_START, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_START_DONE, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, imts_pkg::ACT_SEND, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_ADDR_ACK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      // Zero-length read, with one tick counted down on the way.
      '{'{imts_pkg::OP_READ_CMD, 7'h2a, 16'h0000, 2'd0, 16'd0, 16'd2, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_TICK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_START_DONE, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_ADDR_ACK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_START_DONE, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_ADDR_ACK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, imts_pkg::ACT_DONE, 8'h00, imts_pkg::ST_OK},
      // Zero timeout expires on the first tick.
      '{'{imts_pkg::OP_WRITE_CMD, 7'h01, 16'h0000, 2'd0, 16'd5, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_TICK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, imts_pkg::ACT_DONE, 8'h00, imts_pkg::ST_TIMEOUT},
      // Nack while a memory address byte is on the bus.
      '{'{imts_pkg::OP_READ_CMD, 7'h01, 16'h00c3, 2'd2, 16'd3, 16'd5, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_START_DONE, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_ADDR_ACK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_NACK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      // Nack on the device address.
      '{'{imts_pkg::OP_WRITE_CMD, 7'h7f, 16'h0000, 2'd0, 16'd1, 16'd9, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_START_DONE, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK},
      '{'{imts_pkg::OP_NACK, 7'h00, 16'h0000, 2'd0, 16'd0, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0}, ACT_NONE, 8'h00, imts_pkg::ST_OK}
    };

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = '0;
    dev_addr_i    = '0;
    mem_addr_i    = '0;
    addr_bytes_i  = '0;
    length_i      = '0;
    timeout_ms_i  = '0;
    data_byte_i   = '0;
    bus_busy_i    = 1'b0;
    lines_idle_i  = 1'b0;
    master_mode_i = 1'b0;
    ctrl_extra_i  = 1'b0;
    reset_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      offer(dir_tab[i].item, dir_tab[i].e_act, dir_tab[i].e_data, dir_tab[i].e_stat, changed);
    end

    n_eff = 0;
    iter = 0;
    while (n_eff < RAND_ITEMS) begin
      if (iter == PRESSURE_AT) hold_arm = 1'b1;
      calm = (n_eff >= RAND_ITEMS - CALM_ITEMS);
      offer(next_item(), ACT_NONE, 8'h00, imts_pkg::ST_OK, changed);
      if (changed) n_eff++;
      iter++;
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: short random stalls, plus one long hold-off that lets the
  // request side back up against a full queue.
  initial begin : drain
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    action_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected action %0d byte %02h status %0d last %0b",
                       action_o, byte_out_o, status_o, last_o));
      end else begin
        e = expected_q.pop_front();
        if (action_o !== e.act || byte_out_o !== e.data || status_o !== e.stat ||
            last_o !== e.last) begin
          flag($sformatf("got action %0d byte %02h status %0d last %0b, want %0d %02h %0d %0b",
                         action_o, byte_out_o, status_o, last_o,
                         e.act, e.data, e.stat, e.last));
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
